>>> rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared sizes, codes and cell control types of the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef enum logic [0:0] {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOOKUP,
    CMD_PROMOTE,
    CMD_WRITE_PROMOTE,
    CMD_EVICT_AGE
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_CLAIM
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cmd_op_t           op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] keep;
  } cell_cmd_t;

  // per-cell status, value and rank are zero unless the cell matched
  typedef struct packed {
    logic              match;
    logic [DATA_W-1:0] value;
    logic [RANK_W-1:0] rank;
    logic              claim;
  } cell_stat_t;

endpackage

>>> rtl/core/lkvc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_in_if
// request channel: operation, key and value with valid / ready
// ----------------------------------------------------------------------------
interface lkvc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [lkvc_pkg::DATA_W-1:0]  key;
  logic signed [lkvc_pkg::DATA_W-1:0]  value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

>>> rtl/core/lkvc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_out_if
// result channel: found flag and read value with valid / ready
// ----------------------------------------------------------------------------
interface lkvc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [lkvc_pkg::DATA_W-1:0]  read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

>>> rtl/core/lkvc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cfg_if
// configuration write channel carrying the capacity register
// ----------------------------------------------------------------------------
interface lkvc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lkvc_pkg::CAP_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// The cache is a row of MAX_ENTRIES cells, each holding one key, value, valid
// bit and recency rank (0 is most recent). One request is handled at a time:
// the accept cycle, a lookup cycle in which every cell compares its key, and an
// update cycle; a get (hit or miss) and a set of a present key end with it.
// A set of a new key evicts entries ranked capacity-1 or older and
// ages the rest in the update cycle, then passes a claim token from cell 0
// down the row, one cell per cycle, until the first free cell takes the pair.
// A get's result goes to an output register; the update cycle of a get waits
// while that register is still full and not being taken. Capacity writes of 0
// act as 1 and values above MAX_ENTRIES act as MAX_ENTRIES; lowering the
// capacity evicts only on the next insert.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
  input  logic              clk,
  input  logic              rst_n,
  lkvc_in_if.sink           in_ch,
  lkvc_out_if.source        out_ch,
  lkvc_cfg_if.sink          cfg_ch
);

  localparam int N = lkvc_pkg::MAX_ENTRIES;

  lkvc_pkg::state_t                state_r, state_nxt;
  logic [lkvc_pkg::CAP_W-1:0]      cap_r;

  // request held for the whole item
  logic                            item_op_r;
  logic [lkvc_pkg::DATA_W-1:0]     item_key_r;
  logic [lkvc_pkg::DATA_W-1:0]     item_value_r;

  // output register
  logic                            out_valid_r;
  logic                            out_found_r;
  logic [lkvc_pkg::DATA_W-1:0]     out_value_r;

  lkvc_pkg::cmd_op_t               cmd_op;
  lkvc_pkg::cell_cmd_t             cmd;
  lkvc_pkg::cell_stat_t            stat [N];
  logic [N:0]                      tok;
  logic                            inject;
  logic                            out_load;
  logic                            out_free;
  logic                            in_accept;

  logic                            hit;
  logic                            any_claim;
  logic [lkvc_pkg::DATA_W-1:0]     hit_value;
  logic [lkvc_pkg::RANK_W-1:0]     hit_rank;
  logic [lkvc_pkg::RANK_W-1:0]     keep;

  assign in_ch.ready  = (state_r == lkvc_pkg::ST_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.read_value = out_value_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  // entries kept on insert: effective capacity minus one
  always_comb begin
    if (cap_r == '0) begin
      keep = '0;
    end else if (int'(cap_r) > N) begin
      keep = lkvc_pkg::RANK_W'(N - 1);
    end else begin
      keep = lkvc_pkg::RANK_W'(cap_r - 1'b1);
    end
  end

  // gather the matching cell (at most one) and any claim
  always_comb begin
    hit       = 1'b0;
    any_claim = 1'b0;
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < N; i++) begin
      hit       = hit | stat[i].match;
      any_claim = any_claim | stat[i].claim;
      hit_value = hit_value | stat[i].value;
      hit_rank  = hit_rank | stat[i].rank;
    end
  end

  always_comb begin
    cmd.op       = cmd_op;
    cmd.key      = item_key_r;
    cmd.value    = item_value_r;
    cmd.hit_rank = hit_rank;
    cmd.keep     = keep;
  end

  // claim token enters at cell 0
  assign tok[0] = inject;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lkvc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .token_in  (tok[g]),
      .token_out (tok[g+1]),
      .stat      (stat[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_op    = lkvc_pkg::CMD_NONE;
    inject    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = lkvc_pkg::ST_LOOKUP;
      end
      lkvc_pkg::ST_LOOKUP: begin
        cmd_op    = lkvc_pkg::CMD_LOOKUP;
        state_nxt = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (item_op_r == lkvc_pkg::OP_GET) begin
          // hold the lookup until the result has somewhere to go
          if (out_free) begin
            out_load  = 1'b1;
            cmd_op    = hit ? lkvc_pkg::CMD_PROMOTE : lkvc_pkg::CMD_NONE;
            state_nxt = lkvc_pkg::ST_IDLE;
          end
        end else if (hit) begin
          cmd_op    = lkvc_pkg::CMD_WRITE_PROMOTE;
          state_nxt = lkvc_pkg::ST_IDLE;
        end else begin
          cmd_op    = lkvc_pkg::CMD_EVICT_AGE;
          inject    = 1'b1;
          state_nxt = lkvc_pkg::ST_CLAIM;
        end
      end
      lkvc_pkg::ST_CLAIM: begin
        // done once a free cell took the pair or the token left the row
        if (any_claim || tok[N]) state_nxt = lkvc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      cap_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_op_r    <= in_ch.operation;
      item_key_r   <= in_ch.key;
      item_value_r <= in_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= hit;
      out_value_r <= hit ? hit_value : lkvc_pkg::MISS_VALUE;
    end
  end

endmodule

>>> rtl/core/lkvc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cell
// one cache entry: key, value, valid bit, recency rank and the claim token
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkvc_pkg::cell_cmd_t  cmd,
  input  logic                 token_in,
  output logic                 token_out,
  output lkvc_pkg::cell_stat_t stat
);

  logic                          valid_r, valid_nxt;
  logic [lkvc_pkg::RANK_W-1:0]   rank_r, rank_nxt;
  logic [lkvc_pkg::DATA_W-1:0]   key_r, key_nxt;
  logic [lkvc_pkg::DATA_W-1:0]   value_r, value_nxt;
  logic                          match_r, match_nxt;
  logic                          token_r;
  logic                          match;
  logic                          claim;

  assign match     = valid_r && (key_r == cmd.key);
  assign claim     = token_r && !valid_r;
  assign token_out = token_r && valid_r;

  always_comb begin
    stat.match = match_r;
    stat.value = match_r ? value_r : '0;
    stat.rank  = match_r ? rank_r : '0;
    stat.claim = claim;
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    match_nxt = match_r;
    case (cmd.op)
      lkvc_pkg::CMD_LOOKUP: begin
        match_nxt = match;
      end
      lkvc_pkg::CMD_PROMOTE, lkvc_pkg::CMD_WRITE_PROMOTE: begin
        if (match_r) begin
          rank_nxt = '0;
          if (cmd.op == lkvc_pkg::CMD_WRITE_PROMOTE) value_nxt = cmd.value;
        end else if (valid_r && (rank_r < cmd.hit_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lkvc_pkg::CMD_EVICT_AGE: begin
        if (valid_r && (rank_r >= cmd.keep)) begin
          valid_nxt = 1'b0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
    // free entry that holds the token takes the new pair
    if (claim) begin
      valid_nxt = 1'b1;
      rank_nxt  = '0;
      key_nxt   = cmd.key;
      value_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      token_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      token_r <= token_in;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule
